// ----- design/bdle_pkg.sv -----
package bdle_pkg;

  // command codes
  typedef enum logic [2:0] {
    CMD_LOAD   = 3'd0,
    CMD_WRITE  = 3'd1,
    CMD_FWD    = 3'd2,
    CMD_SCORE  = 3'd3,
    CMD_ARGMAX = 3'd4,
    CMD_UPDATE = 3'd5
  } cmd_t;

  // register indexes
  localparam logic [1:0] REG_LIMIT  = 2'd0;
  localparam logic [1:0] REG_INPUTS = 2'd1;
  localparam logic [1:0] REG_ROWS   = 2'd2;

  localparam int LANES    = 64;
  localparam int ACC_W    = 9;
  localparam int LIMIT_W  = 8;
  localparam int INPUTS_W = 11;
  localparam int ROWS_W   = 8;
  localparam int SCORE_W  = 12;
  localparam int POP_W    = 7;

  // update controls for the lane unit
  typedef struct packed {
    logic [LIMIT_W-1:0] limit;
    logic               target;
  } upd_ctl_t;

  function automatic logic [POP_W-1:0] pop64(input logic [LANES-1:0] x);
    logic [POP_W-1:0] c;
    c = '0;
    for (int i = 0; i < LANES; i++) c = c + POP_W'(x[i]);
    return c;
  endfunction

endpackage

// ----- design/bdle_ram.sv -----
module bdle_ram #(
  parameter int W = 64,
  parameter int D = 16,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

// ----- design/bdle_xnor_unit.sv -----
module bdle_xnor_unit (
  input  logic [bdle_pkg::LANES-1:0]                in_word,
  input  logic [bdle_pkg::LANES-1:0]                wt_word,
  input  logic [bdle_pkg::LANES*bdle_pkg::ACC_W-1:0] acc_word,
  input  logic [bdle_pkg::LANES-1:0]                mask,
  input  bdle_pkg::upd_ctl_t                        ctl,
  output logic [bdle_pkg::POP_W-1:0]                match_cnt,
  output logic [bdle_pkg::LANES-1:0]                new_wt,
  output logic [bdle_pkg::LANES*bdle_pkg::ACC_W-1:0] new_acc
);

  localparam int AW = bdle_pkg::ACC_W;

  // XNOR-popcount over bits in use
  assign match_cnt = bdle_pkg::pop64(~(in_word ^ wt_word) & mask);

  // saturating accumulator per lane
  always_comb begin
    logic signed [AW:0] a;
    logic signed [AW:0] lim;
    lim = $signed({2'b00, ctl.limit});
    for (int i = 0; i < bdle_pkg::LANES; i++) begin
      new_wt[i]          = wt_word[i];
      new_acc[i*AW +: AW] = acc_word[i*AW +: AW];
      a = $signed({acc_word[i*AW+AW-1], acc_word[i*AW +: AW]})
          + ((in_word[i] == ctl.target) ? (AW+1)'(1) : -(AW+1)'(1));
      if (mask[i]) begin
        if (a >= lim) begin
          new_wt[i]           = 1'b1;
          new_acc[i*AW +: AW] = lim[AW-1:0];
        end else if (a <= -lim) begin
          new_wt[i]           = 1'b0;
          new_acc[i*AW +: AW] = AW'(-lim);
        end else begin
          new_acc[i*AW +: AW] = a[AW-1:0];
        end
      end
    end
  end

endmodule

// ----- design/binary_dense_layer_engine.sv -----
// channel | direction | ports
// in      | input     | in_valid/in_ready, command word_index row data target_match
// out     | output    | out_valid/out_ready, result_word score best_row last
// cfg     | input     | cfg_we, cfg_index, cfg_data (write only)
// Forward and argmax scan all rows, score and update a single row, a row being
// words = ceil(inputs/64) words read one word per cycle, unless the output stalls,
// through the shared XNOR-popcount/accumulator unit and its memory read port.
// After reset a clearing pass over 2^(ceil(log2(MAX_ROWS))+ceil(log2(MAX_INPUTS/64)))
// addresses (2048 by default) zeroes weights and accumulators; in_ready stays low.
// A stalled output freezes the scan until the pending beat is taken.
module binary_dense_layer_engine #(
  parameter int MAX_INPUTS = 1024,
  parameter int MAX_ROWS   = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_command,
  input  logic [3:0]  in_word_index,
  input  logic [6:0]  in_row,
  input  logic [63:0] in_data,
  input  logic        in_target_match,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_result_word,
  output logic signed [11:0] out_score,
  output logic [6:0]  out_best_row,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data
);

  localparam int WORDS = (MAX_INPUTS + 63) / 64;
  localparam int WB    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int RB    = $clog2(MAX_ROWS);
  localparam int AB    = RB + WB;
  localparam int DEPTH = 2 ** AB;
  localparam int NB    = $clog2(MAX_INPUTS + 1);
  localparam int LN    = bdle_pkg::LANES;
  localparam int ACCW  = LN * bdle_pkg::ACC_W;

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_SCAN} state_t;

  state_t state_r;
  logic [AB-1:0] clr_r;
  bdle_pkg::cmd_t op_r;
  logic tgt_r;
  logic [RB-1:0] iss_row_r, row_end_r;
  logic [WB-1:0] iss_word_r;
  logic s2_valid_r, s2_last_row_r;
  logic [RB-1:0] s2_row_r;
  logic [WB-1:0] s2_word_r;
  logic [NB-1:0] matches_r, best_m_r;
  logic [RB-1:0] best_row_r;
  logic [LN-1:0] fw_r;
  logic out_valid_r, out_last_r;
  logic [LN-1:0] out_word_r;
  logic [11:0] out_score_r;
  logic [6:0] out_best_r;

  logic [bdle_pkg::LIMIT_W-1:0]  limit_r;
  logic [bdle_pkg::INPUTS_W-1:0] inputs_r;
  logic [bdle_pkg::ROWS_W-1:0]   rows_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r  <= 8'd128;
      inputs_r <= 11'd784;
      rows_r   <= 8'd128;
    end else if (cfg_we) begin
      case (cfg_index)
        bdle_pkg::REG_LIMIT:  limit_r  <= cfg_data[7:0];
        bdle_pkg::REG_INPUTS: inputs_r <= cfg_data;
        bdle_pkg::REG_ROWS:   rows_r   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // effective sizes
  logic [NB-1:0] n_eff;
  logic [RB:0]   nr_eff;
  logic [NB:0]   nw_full;
  logic [WB-1:0] last_word;
  logic [RB-1:0] last_row;
  assign n_eff  = (32'(inputs_r) > 32'(MAX_INPUTS)) ? NB'(MAX_INPUTS) : NB'(inputs_r);
  assign nr_eff = (32'(rows_r) > 32'(MAX_ROWS)) ? (RB+1)'(MAX_ROWS) : (RB+1)'(rows_r);
  assign nw_full  = ({1'b0, n_eff} + (NB+1)'(63)) >> 6;
  assign last_word = (nw_full == '0) ? '0 : WB'(nw_full - (NB+1)'(1));
  assign last_row  = RB'(nr_eff - (RB+1)'(1));

  logic adv, acc_in, row_ok, wi_ok;
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE) && !s2_valid_r && adv;
  assign acc_in   = in_valid && in_ready;
  assign row_ok   = {25'b0, in_row} < 32'(MAX_ROWS);
  assign wi_ok    = {28'b0, in_word_index} < 32'(WORDS);

  // memories
  logic          wt_we, acc_we, ib_we;
  logic [AB-1:0] wt_waddr, rd_addr;
  logic [LN-1:0] wt_wdata, wt_q, ib_q;
  logic [ACCW-1:0] acc_wdata, acc_q;
  assign rd_addr = {iss_row_r, iss_word_r};
  assign ib_we   = acc_in && (in_command == bdle_pkg::CMD_LOAD) && wi_ok;

  bdle_ram #(.W(LN), .D(2 ** WB)) u_input (
    .clk(clk), .we(ib_we), .waddr(WB'(in_word_index)), .wdata(in_data),
    .re(adv), .raddr(iss_word_r), .rdata(ib_q)
  );
  bdle_ram #(.W(LN), .D(DEPTH)) u_weight (
    .clk(clk), .we(wt_we), .waddr(wt_waddr), .wdata(wt_wdata),
    .re(adv), .raddr(rd_addr), .rdata(wt_q)
  );
  bdle_ram #(.W(ACCW), .D(DEPTH)) u_accum (
    .clk(clk), .we(acc_we), .waddr(wt_waddr), .wdata(acc_wdata),
    .re(adv), .raddr(rd_addr), .rdata(acc_q)
  );

  // bit mask of the word under work
  logic signed [NB+1:0] left;
  logic [LN-1:0] mask;
  assign left = $signed({2'b00, n_eff}) - $signed((NB+2)'({s2_word_r, 6'b0}));
  always_comb begin
    if (left >= (NB+2)'(64))    mask = '1;
    else if (left <= 0)         mask = '0;
    else                        mask = ~({LN{1'b1}} << left[5:0]);
  end

  bdle_pkg::upd_ctl_t ctl;
  logic [bdle_pkg::POP_W-1:0] pop;
  logic [LN-1:0] new_wt;
  logic [ACCW-1:0] new_acc;
  assign ctl.limit  = limit_r;
  assign ctl.target = tgt_r;

  bdle_xnor_unit u_unit (
    .in_word(ib_q), .wt_word(wt_q), .acc_word(acc_q), .mask(mask), .ctl(ctl),
    .match_cnt(pop), .new_wt(new_wt), .new_acc(new_acc)
  );

  // row totals in stage two
  logic s2_go, row_done;
  logic [NB-1:0] m_tot;
  logic signed [NB+1:0] sc;
  logic sign_bit, argmax_take;
  logic [LN-1:0] fw_cur;
  assign s2_go    = s2_valid_r && adv;
  assign row_done = s2_word_r == last_word;
  assign m_tot    = ((s2_word_r == '0) ? '0 : matches_r) + NB'(pop);
  assign sc       = $signed({1'b0, m_tot, 1'b0}) - $signed({2'b00, n_eff});
  assign sign_bit = {m_tot, 1'b0} >= {1'b0, n_eff};
  assign fw_cur   = fw_r | (LN'(sign_bit) << 6'(s2_row_r));
  assign argmax_take = (s2_row_r == '0) || (m_tot > best_m_r);

  // memory write port selection
  always_comb begin
    wt_we = 1'b0; acc_we = 1'b0;
    wt_waddr = {RB'(in_row), WB'(in_word_index)};
    wt_wdata = in_data; acc_wdata = new_acc;
    if (state_r == ST_CLEAR) begin
      wt_we = 1'b1; acc_we = 1'b1;
      wt_waddr = clr_r; wt_wdata = '0; acc_wdata = '0;
    end else if (s2_go && op_r == bdle_pkg::CMD_UPDATE) begin
      wt_we = 1'b1; acc_we = 1'b1;
      wt_waddr = {s2_row_r, s2_word_r}; wt_wdata = new_wt;
    end else if (acc_in && in_command == bdle_pkg::CMD_WRITE && wi_ok && row_ok) begin
      wt_we = 1'b1;
    end
  end

  // result selection
  logic emit, e_last;
  logic [LN-1:0] e_word;
  logic [11:0] e_score;
  logic [6:0] e_best;
  always_comb begin
    emit = 1'b0; e_last = 1'b1; e_word = '0; e_score = '0; e_best = '0;
    if (acc_in) begin
      case (in_command)
        bdle_pkg::CMD_FWD:    emit = (nr_eff == '0);
        bdle_pkg::CMD_SCORE:  emit = !row_ok;
        bdle_pkg::CMD_ARGMAX: emit = (nr_eff == '0);
        default: ;
      endcase
    end else if (s2_go && row_done) begin
      case (op_r)
        bdle_pkg::CMD_FWD: begin
          emit   = (6'(s2_row_r) == 6'd63) || s2_last_row_r;
          e_last = s2_last_row_r;
          e_word = fw_cur;
        end
        bdle_pkg::CMD_SCORE: begin
          emit    = 1'b1;
          e_score = 12'(sc);
        end
        bdle_pkg::CMD_ARGMAX: begin
          emit   = s2_last_row_r;
          e_best = 7'(argmax_take ? s2_row_r : best_row_r);
        end
        default: ;
      endcase
    end
  end

  // sequencer, stage two and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      op_r        <= bdle_pkg::CMD_LOAD;
    end else begin
      case (state_r)
        ST_CLEAR: begin
          clr_r <= clr_r + AB'(1);
          if (clr_r == '1) state_r <= ST_IDLE;
        end
        ST_IDLE: begin
          if (acc_in) begin
            op_r       <= bdle_pkg::cmd_t'(in_command);
            tgt_r      <= in_target_match;
            iss_word_r <= '0;
            fw_r       <= '0;
            case (in_command)
              bdle_pkg::CMD_FWD, bdle_pkg::CMD_ARGMAX: begin
                iss_row_r <= '0;
                row_end_r <= last_row;
                if (nr_eff != '0) state_r <= ST_SCAN;
              end
              bdle_pkg::CMD_SCORE, bdle_pkg::CMD_UPDATE: begin
                iss_row_r <= RB'(in_row);
                row_end_r <= RB'(in_row);
                if (row_ok) state_r <= ST_SCAN;
              end
              default: ;
            endcase
          end
        end
        ST_SCAN: begin
          if (adv) begin
            if (iss_word_r == last_word) begin
              iss_word_r <= '0;
              if (iss_row_r == row_end_r) state_r <= ST_IDLE;
              else iss_row_r <= iss_row_r + RB'(1);
            end else begin
              iss_word_r <= iss_word_r + WB'(1);
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase

      // tag of the word read this cycle
      if (adv) begin
        s2_valid_r    <= (state_r == ST_SCAN);
        s2_row_r      <= iss_row_r;
        s2_word_r     <= iss_word_r;
        s2_last_row_r <= (iss_row_r == row_end_r);
      end

      if (s2_go) begin
        matches_r <= m_tot;
        if (row_done && op_r == bdle_pkg::CMD_FWD)
          fw_r <= emit ? '0 : fw_cur;
        if (row_done && op_r == bdle_pkg::CMD_ARGMAX && argmax_take) begin
          best_m_r   <= m_tot;
          best_row_r <= s2_row_r;
        end
      end

      if (emit) begin
        out_valid_r <= 1'b1;
        out_word_r  <= e_word;
        out_score_r <= e_score;
        out_best_r  <= e_best;
        out_last_r  <= e_last;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_word = out_word_r;
  assign out_score       = out_score_r;
  assign out_best_row    = out_best_r;
  assign out_last        = out_last_r;

`ifndef ASSERT_OFF
  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !in_ready) else $error("input taken during clear");
  a_fwd_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && op_r == bdle_pkg::CMD_FWD) |-> !wt_we) else $error("weight write in forward");
  a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> adv) else $error("result emitted over a pending beat");
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && !adv) |=> (s2_valid_r && $stable(s2_word_r) && $stable(s2_row_r)))
    else $error("stage two lost its word in a stall");
`endif

endmodule
